// ===== src/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// csp_pkg: shared types and constants of the command sequence player
// field widths, command kinds, player state codes, register indexes and the
// widths of the delay scaling divider
// ----------------------------------------------------------------------------
package csp_pkg;

  // payload field widths
  localparam int KIND_W   = 3;
  localparam int LIDX_W   = 6;
  localparam int FRAME_W  = 56;
  localparam int DELAY_W  = 16;
  localparam int LOOP_W   = 16;
  localparam int PSTATE_W = 3;

  // configuration register widths and indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 7;
  localparam int SPEED_W    = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_Q8     = 2'd2;

  // command kinds
  localparam logic [KIND_W-1:0] K_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] K_START  = 3'd1;
  localparam logic [KIND_W-1:0] K_PAUSE  = 3'd2;
  localparam logic [KIND_W-1:0] K_RESUME = 3'd3;
  localparam logic [KIND_W-1:0] K_STOP   = 3'd4;
  localparam logic [KIND_W-1:0] K_STEP   = 3'd5;
  localparam logic [KIND_W-1:0] K_LOAD   = 3'd6;

  // player state codes as reported
  localparam logic [PSTATE_W-1:0] ST_IDLE      = 3'd0;
  localparam logic [PSTATE_W-1:0] ST_PLAYING   = 3'd1;
  localparam logic [PSTATE_W-1:0] ST_PAUSED    = 3'd2;
  localparam logic [PSTATE_W-1:0] ST_STOPPED   = 3'd3;
  localparam logic [PSTATE_W-1:0] ST_COMPLETED = 3'd4;

  // speed clamp, q8 units
  localparam logic [SPEED_W-1:0] SPEED_MIN = 13'd13;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 13'd5120;

  // delay scaling divider: (delay << 8) / speed
  localparam int DVD_W  = DELAY_W + 8;
  localparam int DSR_W  = SPEED_W;
  localparam int WAIT_W = 21;

endpackage

// ===== src/csp_if.sv =====
// ----------------------------------------------------------------------------
// csp_if: item channels of the command sequence player
// valid/ready channels for the command items and for the result items
// ----------------------------------------------------------------------------
interface csp_in_if;
  logic                          valid;
  logic                          ready;
  logic [csp_pkg::KIND_W-1:0]    kind;
  logic [csp_pkg::LIDX_W-1:0]    load_index;
  logic [csp_pkg::FRAME_W-1:0]   load_frame;
  logic                          load_frame_present;
  logic [csp_pkg::DELAY_W-1:0]   load_delay_ms;

  modport source (output valid, kind, load_index, load_frame, load_frame_present,
                  load_delay_ms, input ready);
  modport sink   (input valid, kind, load_index, load_frame, load_frame_present,
                  load_delay_ms, output ready);
endinterface

interface csp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic                          step_event;
  logic                          frame_valid;
  logic [csp_pkg::FRAME_W-1:0]   frame_out;
  logic [csp_pkg::LIDX_W-1:0]    played_index;
  logic [csp_pkg::LOOP_W-1:0]    loop_number;
  logic [csp_pkg::PSTATE_W-1:0]  player_state;

  modport source (output valid, accepted, step_event, frame_valid, frame_out,
                  played_index, loop_number, player_state, input ready);
  modport sink   (input valid, accepted, step_event, frame_valid, frame_out,
                  played_index, loop_number, player_state, output ready);
endinterface

// ===== src/csp_ram.sv =====
// ----------------------------------------------------------------------------
// csp_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module csp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/csp_div.sv =====
// ----------------------------------------------------------------------------
// csp_div: serial restoring divider for delay scaling
// one quotient bit per cycle, quotient held until the next start
// ----------------------------------------------------------------------------
module csp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [csp_pkg::DVD_W-1:0]  dividend,
  input  logic [csp_pkg::DSR_W-1:0]  divisor,
  output logic                       done,
  output logic [csp_pkg::DVD_W-1:0]  quotient
);
  import csp_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             fits;

  // one trial subtraction per cycle
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    fits  = (trial >= {1'b0, dsr_r});
  end

  // control and datapath next values
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      rem_nxt = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/command_sequence_player.sv =====
// ----------------------------------------------------------------------------
// command_sequence_player: plays a stored table of command steps on ticks
// step table in a ram, one item at a time, serial divider for wait scaling
// ----------------------------------------------------------------------------
// The player takes one item at a time and gives one result item for each.
// A tick that plays a step goes from acceptance through S_READ, where the
// registered read of the step ram returns the entry, and S_DIV, where the
// one-bit-per-cycle divider scales the delay by the speed, to S_OUT, which
// loads the result register. A single step passes S_READ but skips the
// divider, and every other item goes straight to S_OUT. The next item is
// accepted in the cycle after the result is loaded, while that result still
// waits to be taken. The step table is not cleared at reset; entries read
// before they were loaded give unspecified frames and delays.
module command_sequence_player #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAME_BYTES = 7
) (
  input  logic                            clk,
  input  logic                            rst_n,
  csp_in_if.sink                          in_ch,
  csp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [csp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import csp_pkg::*;

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW      = (8 * FRAME_BYTES > FRAME_W) ? FRAME_W : 8 * FRAME_BYTES;
  localparam int ENTRY_W = FW + DELAY_W + 1;
  localparam logic [COUNT_W-1:0] DEPTH_CAP =
    (TABLE_DEPTH > 127) ? 7'd127 : COUNT_W'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } fsm_t;

  fsm_t                 state_r, state_nxt;

  // configuration registers
  logic [COUNT_W-1:0]   step_count_r;
  logic [LOOP_W-1:0]    repeat_r;
  logic [SPEED_W-1:0]   speed_r;

  // player state
  logic [COUNT_W-1:0]   cur_r, cur_nxt;
  logic [LOOP_W-1:0]    loop_r, loop_nxt;
  logic [WAIT_W-1:0]    wait_r, wait_nxt;
  logic [PSTATE_W-1:0]  ps_r, ps_nxt;

  // result staging
  logic                 res_acc_r;
  logic                 res_step_r;
  logic                 res_div_r;
  logic [LIDX_W-1:0]    res_pidx_r;
  logic                 res_fv_r;
  logic [FRAME_W-1:0]   res_frame_r;

  // output register
  logic                 out_valid_r;
  logic                 o_acc_r, o_step_r, o_fv_r;
  logic [FRAME_W-1:0]   o_frame_r;
  logic [LIDX_W-1:0]    o_pidx_r;
  logic [LOOP_W-1:0]    o_loop_r;
  logic [PSTATE_W-1:0]  o_ps_r;

  logic                 acc;
  logic                 out_free;
  logic [COUNT_W-1:0]   n_used;
  logic                 acc_bit;
  logic                 do_play;
  logic                 do_div;
  logic [COUNT_W-1:0]   play_idx;
  logic [COUNT_W-1:0]   step_next;
  logic                 load_ok;

  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [FW-1:0]        rd_frame;
  logic [DELAY_W-1:0]   rd_delay;
  logic                 rd_present;

  logic [SPEED_W-1:0]   speed_eff;
  logic                 div_start;
  logic                 div_done;
  logic [DVD_W-1:0]     div_q;
  logic [WAIT_W-1:0]    scaled_wait;

  assign acc      = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign n_used   = (step_count_r > DEPTH_CAP) ? DEPTH_CAP : step_count_r;
  assign load_ok  = (32'(in_ch.load_index) < TABLE_DEPTH);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= '0;
      repeat_r     <= 16'd1;
      speed_r      <= 13'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_COUNT:   step_count_r <= cfg_wdata[COUNT_W-1:0];
        CFG_REPEAT_LIMIT: repeat_r     <= cfg_wdata[LOOP_W-1:0];
        CFG_SPEED_Q8:     speed_r      <= cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // command decode at acceptance, wait reload when the divider finishes
  always_comb begin
    cur_nxt   = cur_r;
    loop_nxt  = loop_r;
    wait_nxt  = wait_r;
    ps_nxt    = ps_r;
    acc_bit   = 1'b1;
    do_play   = 1'b0;
    do_div    = 1'b0;
    play_idx  = cur_r;
    step_next = '0;
    if (acc) begin
      unique case (in_ch.kind)
        K_TICK: begin
          if (ps_r == ST_PLAYING) begin
            if (wait_r != '0) begin
              wait_nxt = wait_r - 1'b1;
            end else if (cur_r < n_used) begin
              do_play = 1'b1;
            end else if (n_used != '0 && (repeat_r == '0 || loop_r < repeat_r)) begin
              // next pass starts with step zero on this tick
              play_idx = '0;
              loop_nxt = (loop_r != 16'hFFFF) ? loop_r + 1'b1 : loop_r;
              do_play  = 1'b1;
            end else begin
              ps_nxt = ST_COMPLETED;
            end
            if (do_play) begin
              do_div  = 1'b1;
              cur_nxt = COUNT_W'(play_idx + 1'b1);
            end
          end
        end
        K_START: begin
          if (n_used == '0) begin
            acc_bit = 1'b0;
          end else if (ps_r == ST_PAUSED) begin
            ps_nxt = ST_PLAYING;
          end else if (ps_r != ST_PLAYING) begin
            cur_nxt  = '0;
            loop_nxt = 16'd1;
            wait_nxt = '0;
            ps_nxt   = ST_PLAYING;
          end
        end
        K_PAUSE: begin
          if (ps_r == ST_PLAYING) begin
            ps_nxt   = ST_PAUSED;
            wait_nxt = '0;
          end
        end
        K_RESUME: begin
          if (ps_r == ST_PAUSED) begin
            ps_nxt = ST_PLAYING;
          end
        end
        K_STOP: begin
          ps_nxt   = ST_STOPPED;
          cur_nxt  = '0;
          loop_nxt = 16'd1;
          wait_nxt = '0;
        end
        K_STEP: begin
          if (n_used == '0 || ps_r == ST_PLAYING) begin
            acc_bit = 1'b0;
          end else begin
            play_idx  = (cur_r >= n_used) ? '0 : cur_r;
            step_next = COUNT_W'(play_idx + 1'b1);
            cur_nxt   = (step_next >= n_used) ? '0 : step_next;
            wait_nxt  = '0;
            ps_nxt    = ST_PAUSED;
            do_play   = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (state_r == S_DIV && div_done) begin
      wait_nxt = scaled_wait;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc) state_nxt = do_play ? S_READ : S_OUT;
      S_READ: state_nxt = res_div_r ? S_DIV : S_OUT;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and player state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      loop_r      <= 16'd1;
      wait_r      <= '0;
      ps_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      loop_r  <= loop_nxt;
      wait_r  <= wait_nxt;
      ps_r    <= ps_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // step table: frame, delay and present flag in one entry
  assign ram_wdata  = {in_ch.load_frame_present, in_ch.load_delay_ms,
                       in_ch.load_frame[FW-1:0]};
  assign rd_frame   = ram_rdata[FW-1:0];
  assign rd_delay   = ram_rdata[FW+DELAY_W-1:FW];
  assign rd_present = ram_rdata[ENTRY_W-1];

  csp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (acc && in_ch.kind == K_LOAD && load_ok),
    .waddr (AW'(in_ch.load_index)),
    .wdata (ram_wdata),
    .re    (acc && do_play),
    .raddr (AW'(play_idx)),
    .rdata (ram_rdata)
  );

  // wait scaling: (delay << 8) / clamped speed, minus one, floored at zero
  assign speed_eff   = (speed_r < SPEED_MIN) ? SPEED_MIN :
                       (speed_r > SPEED_MAX) ? SPEED_MAX : speed_r;
  assign div_start   = (state_r == S_READ) && res_div_r;
  assign scaled_wait = (div_q == '0) ? '0 : WAIT_W'(div_q - 1'b1);

  csp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({rd_delay, 8'd0}),
    .divisor  (speed_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // result staging
  always_ff @(posedge clk) begin
    if (acc) begin
      res_acc_r   <= acc_bit;
      res_step_r  <= do_play;
      res_div_r   <= do_div;
      res_pidx_r  <= do_play ? LIDX_W'(play_idx) : '0;
      res_fv_r    <= 1'b0;
      res_frame_r <= '0;
    end else if (state_r == S_READ) begin
      res_fv_r    <= rd_present;
      res_frame_r <= rd_present ? FRAME_W'(rd_frame) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      o_acc_r   <= res_acc_r;
      o_step_r  <= res_step_r;
      o_fv_r    <= res_fv_r;
      o_frame_r <= res_frame_r;
      o_pidx_r  <= res_pidx_r;
      o_loop_r  <= loop_r;
      o_ps_r    <= ps_r;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = o_acc_r;
  assign out_ch.step_event   = o_step_r;
  assign out_ch.frame_valid  = o_fv_r;
  assign out_ch.frame_out    = o_frame_r;
  assign out_ch.played_index = o_pidx_r;
  assign out_ch.loop_number  = o_loop_r;
  assign out_ch.player_state = o_ps_r;

  // divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the wait scaling phase");

  // an item other than a tick or a step goes straight to the result
  a_no_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.kind != K_TICK && in_ch.kind != K_STEP) |=> state_r == S_OUT)
    else $error("non-playing item did not go to the result");

  // stop resets the position
  a_stop_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.kind == K_STOP) |=>
      (ps_r == ST_STOPPED && cur_r == '0 && loop_r == 16'd1 && wait_r == '0))
    else $error("stop left the player position set");

  // a pending wait exists only while playing
  a_wait_only_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r != '0) |-> ps_r == ST_PLAYING)
    else $error("wait pending outside playing");

  // a loaded result shows up on the output
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after loading");

endmodule
